// File: sv/rebd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rebd_pkg
// Shared types, event codes and register indexes for the rotary encoder and
// push-button decoder.
// ----------------------------------------------------------------------------
package rebd_pkg;

    // Item kinds
    localparam logic OP_PIN  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Pin selects
    localparam logic [1:0] PIN_A    = 2'd0;
    localparam logic [1:0] PIN_B    = 2'd1;
    localparam logic [1:0] PIN_BTN  = 2'd2;
    localparam logic [1:0] PIN_NONE = 2'd3;

    // Result event codes
    localparam logic [2:0] EV_CW     = 3'd0;
    localparam logic [2:0] EV_CCW    = 3'd1;
    localparam logic [2:0] EV_PRESS  = 3'd2;
    localparam logic [2:0] EV_LONG   = 3'd3;
    localparam logic [2:0] EV_DOUBLE = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [1:0] CFG_LONG     = 2'd1;
    localparam logic [1:0] CFG_DOUBLE   = 2'd2;

    // Register reset values
    localparam logic [15:0] DEBOUNCE_RST = 16'd20;
    localparam logic [15:0] LONG_RST     = 16'd1000;
    localparam logic [15:0] DOUBLE_RST   = 16'd300;

    typedef struct packed {
        logic       op;
        logic [1:0] pin;
        logic       level;
    } t_item;

    typedef struct packed {
        logic       valid;
        logic [2:0] code;
    } t_result;

    // Direction from the truncated remainder of (code - prev) by 4
    function automatic t_result quad_dir(input logic [2:0] code, input logic [2:0] prev);
        logic signed [3:0] diff;
        logic        [3:0] mag;
        logic        [1:0] rem;
        t_result           res;
        diff = $signed({1'b0, code}) - $signed({1'b0, prev});
        mag  = diff[3] ? 4'(-diff) : diff;
        rem  = mag[1:0];
        res.valid = 1'b0;
        res.code  = EV_CW;
        if ((!diff[3] && rem == 2'd3) || (diff[3] && rem == 2'd1)) begin
            res.valid = 1'b1;
            res.code  = EV_CW;
        end else if ((!diff[3] && rem == 2'd1) || (diff[3] && rem == 2'd3)) begin
            res.valid = 1'b1;
            res.code  = EV_CCW;
        end
        return res;
    endfunction

endpackage

// File: sv/rotary_encoder_button_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_button_decoder
// Decodes encoder pin changes and button edges, timed by millisecond ticks.
// ----------------------------------------------------------------------------
// Flow: a request lands in the input register, then its result loads into the
//   result register once that register is free; items that give no result
//   leave no output.
// Throughput: one request per cycle while the result output is not stalled; the state update is single-pass logic.
// Reset: synchronous active-low; clears counters, encoder state and the
//   configuration registers to 20 / 1000 / 300 ms.
module rotary_encoder_button_decoder #(
    parameter int TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [1:0] pin, [2] level, [7:3] zero
    input  logic        s_axis_tuser,   // [0] operation
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] event_res, [7:3] zero
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import rebd_pkg::*;

    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    logic [2:0]  r_out_event;
    logic [15:0] r_deb, r_long, r_dbl;
    logic        advance, step_en;
    t_result     btn_res, quad_res;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb  <= DEBOUNCE_RST;
            r_long <= LONG_RST;
            r_dbl  <= DOUBLE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE: r_deb  <= i_cfg_data;
                CFG_LONG:     r_long <= i_cfg_data;
                CFG_DOUBLE:   r_dbl  <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // Handshake: the input register moves on whenever the result register is free
    assign advance       = !r_out_valid || m_axis_tready;
    assign step_en       = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.op    <= s_axis_tuser;
            r_in.pin   <= s_axis_tdata[1:0];
            r_in.level <= s_axis_tdata[2];
        end
    end

    rebd_button #(
        .TIME_BITS (TIME_BITS)
    ) u_button (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (step_en),
        .i_item        (r_in),
        .i_debounce_ms (r_deb),
        .i_long_ms     (r_long),
        .i_double_ms   (r_dbl),
        .o_res         (btn_res)
    );

    rebd_quad u_quad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (step_en),
        .i_item  (r_in),
        .i_block (btn_res.valid),
        .o_res   (quad_res)
    );

    // Result register; a button result takes priority over a direction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step_en && (btn_res.valid || quad_res.valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_event <= btn_res.valid ? btn_res.code : quad_res.code;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_event};

    // Assertions
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_event == EV_CW || r_out_event == EV_CCW ||
                         r_out_event == EV_PRESS || r_out_event == EV_LONG ||
                         r_out_event == EV_DOUBLE))
        else $error("result code out of range");

    a_tick_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_en && r_in.op == OP_TICK) |=> (!r_out_valid || r_out_event == EV_PRESS))
        else $error("tick gave a non-press result");

    a_pin_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_en && r_in.op == OP_PIN && r_in.pin == PIN_NONE) |=> !r_out_valid)
        else $error("unused pin gave a result");

    a_btn_no_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_en && r_in.op == OP_PIN && r_in.pin == PIN_BTN) |=>
        (!r_out_valid || r_out_event == EV_LONG || r_out_event == EV_DOUBLE))
        else $error("button edge gave a direction or single press");

endmodule

// File: sv/rebd_button.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rebd_button
// Millisecond counter and debounced button timing: long, double and delayed
// single press detection.
// ----------------------------------------------------------------------------
module rebd_button #(
    parameter int TIME_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  rebd_pkg::t_item  i_item,
    input  logic [15:0]      i_debounce_ms,
    input  logic [15:0]      i_long_ms,
    input  logic [15:0]      i_double_ms,
    output rebd_pkg::t_result o_res
);
    import rebd_pkg::*;

    logic [TIME_BITS-1:0] r_now, r_evt, r_press, r_rel;
    logic [TIME_BITS-1:0] n_now, n_evt, n_press, n_rel;
    logic                 r_pend, n_pend;

    logic [TIME_BITS-1:0] deb_w, long_w, dbl_w;
    logic [TIME_BITS-1:0] now_inc, tick_since_rel;
    logic [TIME_BITS-1:0] since_evt, since_rel, since_press;

    assign deb_w  = TIME_BITS'(i_debounce_ms);
    assign long_w = TIME_BITS'(i_long_ms);
    assign dbl_w  = TIME_BITS'(i_double_ms);

    assign now_inc        = r_now + 1'b1;
    assign tick_since_rel = now_inc - r_rel;
    assign since_evt      = r_now - r_evt;
    assign since_rel      = r_now - r_rel;
    assign since_press    = r_now - r_press;

    // Next state and press result for one item
    always_comb begin
        n_now   = r_now;
        n_evt   = r_evt;
        n_press = r_press;
        n_rel   = r_rel;
        n_pend  = r_pend;
        o_res.valid = 1'b0;
        o_res.code  = EV_PRESS;
        if (i_en) begin
            if (i_item.op == OP_TICK) begin
                n_now = now_inc;
                if (r_pend && tick_since_rel > dbl_w) begin
                    n_pend      = 1'b0;
                    o_res.valid = 1'b1;
                    o_res.code  = EV_PRESS;
                end
            end else if (i_item.pin == PIN_BTN && since_evt > deb_w) begin
                if (!i_item.level) begin
                    // press edge
                    n_pend  = 1'b0;
                    n_press = r_now;
                end else if (since_rel > deb_w) begin
                    // release edge
                    if (since_press > long_w) begin
                        o_res.valid = 1'b1;
                        o_res.code  = EV_LONG;
                    end else if (since_rel < dbl_w) begin
                        o_res.valid = 1'b1;
                        o_res.code  = EV_DOUBLE;
                    end else begin
                        n_pend = 1'b1;
                    end
                    n_rel = r_now;
                end
                n_evt = r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now   <= '0;
            r_evt   <= '0;
            r_press <= '0;
            r_rel   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_now   <= n_now;
            r_evt   <= n_evt;
            r_press <= n_press;
            r_rel   <= n_rel;
            r_pend  <= n_pend;
        end
    end

endmodule

// File: sv/rebd_quad.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rebd_quad
// Quadrature encoder state: pin levels, previous code and previous pin, and
// the clockwise / counterclockwise decision.
// ----------------------------------------------------------------------------
module rebd_quad (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  rebd_pkg::t_item   i_item,
    input  logic              i_block,
    output rebd_pkg::t_result o_res
);
    import rebd_pkg::*;

    logic       r_a, r_b, n_a, n_b;
    logic [2:0] r_prev_code, n_prev_code;
    logic [1:0] r_prev_pin, n_prev_pin;
    logic [2:0] code;
    logic       pin_event;
    t_result    dir;

    // Pin events only; ticks and the unused pin leave the encoder alone
    assign pin_event = i_en && i_item.op == OP_PIN && i_item.pin != PIN_NONE;

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        case (i_item.pin)
            PIN_A:   n_a = i_item.level;
            PIN_B:   n_b = i_item.level;
            default: ;
        endcase
    end

    assign code = {n_a, n_b, n_a ^ n_b};
    assign dir  = quad_dir(code, r_prev_code);

    assign n_prev_code = pin_event ? code : r_prev_code;
    assign n_prev_pin  = pin_event ? i_item.pin : r_prev_pin;

    // Direction only on a change of pin with A^B set, and no button result
    assign o_res.valid = pin_event && i_item.pin != r_prev_pin && code[0] && !i_block
                         && dir.valid;
    assign o_res.code  = dir.code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a         <= 1'b0;
            r_b         <= 1'b0;
            r_prev_code <= 3'd0;
            r_prev_pin  <= PIN_NONE;
        end else begin
            if (pin_event) begin
                r_a <= n_a;
                r_b <= n_b;
            end
            r_prev_code <= n_prev_code;
            r_prev_pin  <= n_prev_pin;
        end
    end

endmodule
